// File: sv/crcfr_pkg.sv
// Shared types and constants for the CRC-16 framed message receiver.
package crcfr_pkg;

  // Receive phase of the frame parser; codes 6 and 7 are not used.
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_BODY   = 3'd3,
    PH_CRC_HI = 3'd4,
    PH_CRC_LO = 3'd5
  } phase_t;

  // Event reported for each received byte.
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_HEARTBEAT = 2'd1,
    EV_CRC_ERR   = 2'd2,
    EV_FRAME_ERR = 2'd3
  } ev_t;

  // One result beat handed from the parser to the output buffer.
  typedef struct packed {
    logic valid;
    ev_t  event_res;
  } ev_beat_t;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CRC_W  = 16;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h7E;
  localparam logic [BYTE_W-1:0] TYPE_HEARTBEAT   = 8'h01;
  localparam logic [CRC_W-1:0]  CRC_INIT         = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY         = 16'h1021;

endpackage

// File: sv/crcfr_parser.sv
// Frame parser: phase state machine and byte-wide CRC-16/CCITT-FALSE update.
module crcfr_parser import crcfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] start_marker,
  output ev_beat_t          beat
);

  // Eight MSB-first shift steps of the CRC for one byte.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = c ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (r[CRC_W-1]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  phase_t            phase_r, phase_nxt;
  logic              is_hb_r, is_hb_nxt;
  logic [BYTE_W-1:0] length_r, length_nxt;
  logic [BYTE_W-1:0] count_r, count_nxt;
  logic [BYTE_W-1:0] count_inc;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [CRC_W-1:0]  crc_upd;
  logic [BYTE_W-1:0] sent_hi_r, sent_hi_nxt;
  ev_t               ev_nxt;

  assign crc_upd   = crc_byte(crc_r, rx_byte);
  assign count_inc = count_r + 8'd1;

  // Next state and event for the byte on the input.
  always_comb begin
    phase_nxt   = phase_r;
    is_hb_nxt   = is_hb_r;
    length_nxt  = length_r;
    count_nxt   = count_r;
    crc_nxt     = crc_r;
    sent_hi_nxt = sent_hi_r;
    ev_nxt      = EV_NONE;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == start_marker) begin
          is_hb_nxt   = 1'b0;
          length_nxt  = '0;
          count_nxt   = '0;
          crc_nxt     = CRC_INIT;
          sent_hi_nxt = '0;
          phase_nxt   = PH_TYPE;
        end
      end
      PH_TYPE: begin
        is_hb_nxt = (rx_byte == TYPE_HEARTBEAT);
        crc_nxt   = crc_upd;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        length_nxt = rx_byte;
        count_nxt  = '0;
        crc_nxt    = crc_upd;
        phase_nxt  = (rx_byte == '0) ? PH_CRC_HI : PH_BODY;
      end
      PH_BODY: begin
        crc_nxt   = crc_upd;
        count_nxt = count_inc;
        if (count_inc >= length_r) begin
          phase_nxt = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        sent_hi_nxt = rx_byte;
        phase_nxt   = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if ({sent_hi_r, rx_byte} != crc_r) begin
          ev_nxt = EV_CRC_ERR;
        end else if (is_hb_r) begin
          ev_nxt = EV_HEARTBEAT;
        end else begin
          ev_nxt = EV_FRAME_ERR;
        end
        phase_nxt   = PH_HUNT;
        is_hb_nxt   = 1'b0;
        length_nxt  = '0;
        count_nxt   = '0;
        crc_nxt     = CRC_INIT;
        sent_hi_nxt = '0;
      end
      default: begin
        ev_nxt      = EV_FRAME_ERR;
        phase_nxt   = PH_HUNT;
        is_hb_nxt   = 1'b0;
        length_nxt  = '0;
        count_nxt   = '0;
        crc_nxt     = CRC_INIT;
        sent_hi_nxt = '0;
      end
    endcase
  end

  // Frame state advances only on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      is_hb_r   <= 1'b0;
      length_r  <= '0;
      count_r   <= '0;
      crc_r     <= CRC_INIT;
      sent_hi_r <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      is_hb_r   <= is_hb_nxt;
      length_r  <= length_nxt;
      count_r   <= count_nxt;
      crc_r     <= crc_nxt;
      sent_hi_r <= sent_hi_nxt;
    end
  end

  // Every accepted byte yields exactly one event.
  assign beat.valid     = accept;
  assign beat.event_res = ev_nxt;

`ifndef SYNTHESIS
  // The body counter never passes the announced length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> count_r < length_r)
    else $error("body count passed length");

  // A frame end always returns the parser to hunting.
  a_end_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_CRC_LO |=> phase_r == PH_HUNT && crc_r == CRC_INIT)
    else $error("frame end did not return to hunting");

  // A nonzero event only comes at the last CRC byte or from a bad phase.
  a_event_src: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev_nxt != EV_NONE |-> phase_r != PH_HUNT && phase_r != PH_TYPE &&
      phase_r != PH_LEN && phase_r != PH_BODY && phase_r != PH_CRC_HI)
    else $error("event outside frame end");
`endif

endmodule

// File: sv/crcfr_out_buf.sv
// Output register with one skid entry for the event channel.
module crcfr_out_buf import crcfr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ev_beat_t push,
  output logic     full,
  output logic     out_valid,
  output ev_t      out_event_res,
  input  logic     out_stall
);

  logic main_v_r;
  ev_t  main_d_r;
  logic skid_v_r;
  ev_t  skid_d_r;
  logic pop;

  assign pop = main_v_r && !out_stall;

  // Valid bits of the two entries.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push.valid) begin
      if (!main_v_r || pop) begin
        main_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  // Data of the two entries; the skid entry drains into the main one.
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_d_r <= skid_d_r;
      end
    end else if (push.valid) begin
      if (!main_v_r || pop) begin
        main_d_r <= push.event_res;
      end else begin
        skid_d_r <= push.event_res;
      end
    end
  end

  assign full          = skid_v_r;
  assign out_valid     = main_v_r;
  assign out_event_res = main_d_r;

`ifndef SYNTHESIS
  // The skid entry is only used behind a held main entry.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry without main entry");

  // No beat is pushed while the buffer reports full.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push.valid)
    else $error("push into full buffer");

  // A stalled skid entry is released once the main entry is taken.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && pop |=> !skid_v_r && main_v_r && main_d_r == $past(skid_d_r))
    else $error("skid entry not drained");
`endif

endmodule

// File: sv/crc16_framed_message_receiver_unit.sv
// Top level of the CRC-16 framed message receiver.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_rx_byte[7:0]
//   out_     output     out_valid / out_stall  out_event_res[1:0]
//   cfg_     input      cfg_wr_en              cfg_wr_data[7:0] (start marker)
//
// One byte is taken per cycle while in_stall is low; its event is registered in
// the output or skid entry. Parser state and the byte-wide CRC register together.
// Reset returns the parser to hunting and the start marker to 0x7E.
// A stalled output holds one more event in a skid entry; in_stall rises only
// when both entries are full.
module crc16_framed_message_receiver_unit import crcfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_event_res,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data
);

  logic [BYTE_W-1:0] start_marker_r;
  logic              in_accept;
  logic              buf_full;
  ev_beat_t          beat;
  ev_t               out_ev;

  // Start marker configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
    end else if (cfg_wr_en) begin
      start_marker_r <= cfg_wr_data;
    end
  end

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !in_stall;

  // Frame parser.
  crcfr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .rx_byte      (in_rx_byte),
    .start_marker (start_marker_r),
    .beat         (beat)
  );

  // Event output buffer.
  crcfr_out_buf u_out_buf (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (beat),
    .full          (buf_full),
    .out_valid     (out_valid),
    .out_event_res (out_ev),
    .out_stall     (out_stall)
  );

  assign out_event_res = out_ev;

endmodule
